### rtl/tbg_pkg.sv
// Package for the tile box to global filter: shared widths, codes, config
// and inter-stage structs. No dependencies.

package tbg_pkg;

  // field widths fixed by the interface
  localparam int LOC_W      = 13;
  localparam int EXT_W      = 14;
  localparam int OFF_W      = 14;
  localparam int PAD_W      = 10;
  localparam int SIZE_W     = 15;
  localparam int OUT_W      = 16;
  localparam int EXTENT_W   = 12;
  localparam int ASPECT_W   = 12;
  localparam int SCALE_W    = 10;
  localparam int VERDICT_W  = 3;
  // shifted and clamped coordinate width
  localparam int CRD_W      = 17;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [EXTENT_W-1:0] MAX_EXTENT_RST = EXTENT_W'(300);
  localparam logic [ASPECT_W-1:0] MAX_ASPECT_RST = ASPECT_W'(1280);
  localparam logic [SCALE_W-1:0]  RESCALE_RST    = SCALE_W'(256);

  localparam logic signed [CRD_W-1:0] CRD_ZERO = '0;
  localparam logic signed [CRD_W-1:0] CRD_ONE  = CRD_W'(1);

  typedef enum logic [VERDICT_W-1:0] {
    V_KEPT   = 3'd0,
    V_LARGE  = 3'd1,
    V_ASPECT = 3'd2,
    V_NEG    = 3'd3,
    V_BEYOND = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    REG_MAX_EXTENT = 2'd0,
    REG_MAX_ASPECT = 2'd1,
    REG_RESCALE    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [EXTENT_W-1:0] max_extent;
    logic [ASPECT_W-1:0] max_aspect;
    logic [SCALE_W-1:0]  rescale;
  } cfg_t;

  // box after shift and clamp, with the early verdict
  typedef struct packed {
    verdict_e                verdict;
    logic signed [CRD_W-1:0] x0;
    logic signed [CRD_W-1:0] x1;
    logic signed [CRD_W-1:0] y0;
    logic signed [CRD_W-1:0] y1;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
  } geom_t;

  // width of the rescale products and sums for a given fraction width
  function automatic int rescale_w(input int frac);
    return (((CRD_W + 1 + frac) > (2 * CRD_W - 5)) ? (CRD_W + 1 + frac)
                                                   : (2 * CRD_W - 5)) + 1;
  endfunction

  // width of the coordinates after rescale
  function automatic int coord_w(input int frac);
    return rescale_w(frac) - frac;
  endfunction

endpackage

### rtl/tbg_if.sv
// Handshake interfaces for box items and result items.
// Depends on tbg_pkg for field widths.

interface tbg_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tbg_pkg::LOC_W-1:0]       local_left;
  logic signed [tbg_pkg::LOC_W-1:0]       local_right;
  logic signed [tbg_pkg::LOC_W-1:0]       local_top;
  logic signed [tbg_pkg::LOC_W-1:0]       local_bottom;
  logic [tbg_pkg::OFF_W-1:0]              tile_row_offset;
  logic [tbg_pkg::OFF_W-1:0]              tile_col_offset;
  logic [tbg_pkg::PAD_W-1:0]              tile_pad;
  logic [tbg_pkg::SIZE_W-1:0]             image_width;
  logic [tbg_pkg::SIZE_W-1:0]             image_height;

  modport source (
    output valid, local_left, local_right, local_top, local_bottom,
           tile_row_offset, tile_col_offset, tile_pad, image_width, image_height,
    input  ready
  );
  modport sink (
    input  valid, local_left, local_right, local_top, local_bottom,
           tile_row_offset, tile_col_offset, tile_pad, image_width, image_height,
    output ready
  );
endinterface

interface tbg_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [tbg_pkg::VERDICT_W-1:0]          verdict;
  logic signed [tbg_pkg::OUT_W-1:0]       global_left;
  logic signed [tbg_pkg::OUT_W-1:0]       global_right;
  logic signed [tbg_pkg::OUT_W-1:0]       global_top;
  logic signed [tbg_pkg::OUT_W-1:0]       global_bottom;

  modport source (
    output valid, verdict, global_left, global_right, global_top, global_bottom,
    input  ready
  );
  modport sink (
    input  valid, verdict, global_left, global_right, global_top, global_bottom,
    output ready
  );
endinterface

### rtl/tbg_cfg.sv
// APB register file: max_box_extent, max_aspect_q8, rescale_q8.
// Depends on tbg_pkg.

module tbg_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tbg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tbg_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tbg_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output tbg_pkg::cfg_t                    cfg_o
);
  import tbg_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e idx;
  logic     wr_en;

  assign idx    = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_extent <= MAX_EXTENT_RST;
      cfg_q.max_aspect <= MAX_ASPECT_RST;
      cfg_q.rescale    <= RESCALE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_EXTENT: cfg_q.max_extent <= pwdata[EXTENT_W-1:0];
        REG_MAX_ASPECT: cfg_q.max_aspect <= pwdata[ASPECT_W-1:0];
        REG_RESCALE:    cfg_q.rescale    <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_EXTENT: prdata = CFG_DATA_W'(cfg_q.max_extent);
      REG_MAX_ASPECT: prdata = CFG_DATA_W'(cfg_q.max_aspect);
      REG_RESCALE:    prdata = CFG_DATA_W'(cfg_q.rescale);
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/tbg_geom.sv
// Two pipeline stages: extents, size and aspect tests, shift to global
// coordinates and clamp to the image. Depends on tbg_pkg.

module tbg_geom #(
  parameter int FRAC_BITS  = 8,
  parameter int IMAGE_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbg_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [tbg_pkg::LOC_W-1:0] local_left_i,
  input  logic signed [tbg_pkg::LOC_W-1:0] local_right_i,
  input  logic signed [tbg_pkg::LOC_W-1:0] local_top_i,
  input  logic signed [tbg_pkg::LOC_W-1:0] local_bottom_i,
  input  logic [tbg_pkg::OFF_W-1:0]        tile_row_offset_i,
  input  logic [tbg_pkg::OFF_W-1:0]        tile_col_offset_i,
  input  logic [tbg_pkg::PAD_W-1:0]        tile_pad_i,
  input  logic [tbg_pkg::SIZE_W-1:0]       image_width_i,
  input  logic [tbg_pkg::SIZE_W-1:0]       image_height_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output tbg_pkg::geom_t                   geom_o
);
  import tbg_pkg::*;

  // holds both q*extent and extent<<FRAC_BITS
  localparam int AW = ((EXT_W + FRAC_BITS) > (ASPECT_W + EXT_W + 1)) ?
                      (EXT_W + FRAC_BITS + 1) : (ASPECT_W + EXT_W + 1);
  localparam logic [OFF_W-1:0]  OFF_MASK  = OFF_W'((1 << IMAGE_BITS) - 1);
  localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_W'((1 << (IMAGE_BITS + 1)) - 1);

  logic en1, en2;

  // stage 1
  logic signed [EXT_W-1:0] dx_d, dy_d;
  logic                    large_d;
  logic signed [AW-1:0]    q_ext, dx_ext, dy_ext, pdx_d, pdy_d;
  logic signed [CRD_W-1:0] row_s, col_s, pad_s;
  logic signed [CRD_W-1:0] xl_d, xr_d, yt_d, yb_d;

  logic                    s1_vld_q;
  logic signed [EXT_W-1:0] dx_q, dy_q;
  logic                    large_q;
  logic signed [AW-1:0]    pdx_q, pdy_q;
  logic signed [CRD_W-1:0] xl_q, xr_q, yt_q, yb_q;
  logic [SIZE_W-1:0]       w_q, h_q;

  // stage 2
  logic signed [AW-1:0]    lhs_x, lhs_y;
  logic                    over_x, over_y, aspect;
  logic signed [CRD_W-1:0] wm1, hm1;
  geom_t                   geom_d;

  logic                    s2_vld_q;
  geom_t                   geom_q;

  assign en2     = !s2_vld_q || ready_i;
  assign en1     = !s1_vld_q || en2;
  assign ready_o = en1;
  assign valid_o = s2_vld_q;
  assign geom_o  = geom_q;

  assign dx_d    = EXT_W'(local_right_i) - EXT_W'(local_left_i);
  assign dy_d    = EXT_W'(local_bottom_i) - EXT_W'(local_top_i);
  assign large_d = (dx_d > $signed({2'b00, cfg_i.max_extent})) ||
                   (dy_d > $signed({2'b00, cfg_i.max_extent}));

  assign q_ext  = AW'($signed({1'b0, cfg_i.max_aspect}));
  assign dx_ext = AW'(dx_d);
  assign dy_ext = AW'(dy_d);
  assign pdx_d  = q_ext * dx_ext;
  assign pdy_d  = q_ext * dy_ext;

  assign row_s = $signed({{(CRD_W-OFF_W){1'b0}}, tile_row_offset_i & OFF_MASK});
  assign col_s = $signed({{(CRD_W-OFF_W){1'b0}}, tile_col_offset_i & OFF_MASK});
  assign pad_s = $signed({{(CRD_W-PAD_W){1'b0}}, tile_pad_i});
  assign xl_d  = CRD_W'(local_left_i) + col_s - pad_s;
  assign xr_d  = CRD_W'(local_right_i) + col_s - pad_s;
  assign yt_d  = CRD_W'(local_top_i) + row_s - pad_s;
  assign yb_d  = CRD_W'(local_bottom_i) + row_s - pad_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q <= valid_i;
      if (en2) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      large_q <= large_d;
      pdx_q   <= pdx_d;
      pdy_q   <= pdy_d;
      xl_q    <= xl_d;
      xr_q    <= xr_d;
      yt_q    <= yt_d;
      yb_q    <= yb_d;
      w_q     <= image_width_i & SIZE_MASK;
      h_q     <= image_height_i & SIZE_MASK;
    end
  end

  // exact ratio tests; the divisor's sign flips the comparison
  assign lhs_x  = AW'(dx_q) <<< FRAC_BITS;
  assign lhs_y  = AW'(dy_q) <<< FRAC_BITS;
  assign over_x = (dy_q > 0) ? (lhs_x > pdy_q) : (lhs_x < pdy_q);
  assign over_y = (dx_q > 0) ? (lhs_y > pdx_q) : (lhs_y < pdx_q);
  assign aspect = (dx_q == 0) || (dy_q == 0) || over_x || over_y;

  assign wm1 = $signed({{(CRD_W-SIZE_W){1'b0}}, w_q}) - CRD_ONE;
  assign hm1 = $signed({{(CRD_W-SIZE_W){1'b0}}, h_q}) - CRD_ONE;

  always_comb begin
    priority if (large_q) begin
      geom_d.verdict = V_LARGE;
    end else if (aspect) begin
      geom_d.verdict = V_ASPECT;
    end else begin
      geom_d.verdict = V_KEPT;
    end
    geom_d.x0 = (xl_q < CRD_ZERO) ? CRD_ZERO : xl_q;
    geom_d.x1 = (xr_q > wm1) ? wm1 : xr_q;
    geom_d.y0 = (yt_q < CRD_ZERO) ? CRD_ZERO : yt_q;
    geom_d.y1 = (yb_q > hm1) ? hm1 : yb_q;
    geom_d.w  = w_q;
    geom_d.h  = h_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2) geom_q <= geom_d;
  end

endmodule

### rtl/tbg_rescale.sv
// Two pipeline stages: rescale of the clamped box about its centre,
// truncating toward zero. Depends on tbg_pkg.

module tbg_rescale #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic [tbg_pkg::SCALE_W-1:0]                         rescale_i,
  input  logic                                                valid_i,
  output logic                                                ready_o,
  input  tbg_pkg::geom_t                                      geom_i,
  output logic                                                valid_o,
  input  logic                                                ready_i,
  output tbg_pkg::verdict_e                                   verdict_o,
  output logic signed [tbg_pkg::coord_w(FRAC_BITS)-1:0]       x0_o,
  output logic signed [tbg_pkg::coord_w(FRAC_BITS)-1:0]       x1_o,
  output logic signed [tbg_pkg::coord_w(FRAC_BITS)-1:0]       y0_o,
  output logic signed [tbg_pkg::coord_w(FRAC_BITS)-1:0]       y1_o,
  output logic [tbg_pkg::SIZE_W-1:0]                          w_o,
  output logic [tbg_pkg::SIZE_W-1:0]                          h_o
);
  import tbg_pkg::*;

  localparam int RW    = rescale_w(FRAC_BITS);
  localparam int NW    = coord_w(FRAC_BITS);
  localparam int UNITY = 1 << FRAC_BITS;
  localparam logic signed [RW-1:0] BIAS = RW'((1 << (FRAC_BITS + 1)) - 1);

  function automatic logic signed [NW-1:0] trunc_q(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] biased;
    biased  = v[RW-1] ? (v + BIAS) : v;
    trunc_q = NW'(biased >>> (FRAC_BITS + 1));
  endfunction

  logic en3, en4;

  // stage 3: centre and half extent in 1/2^(FRAC_BITS+1) pixel units
  logic signed [RW-1:0] s_ext, x0_e, x1_e, y0_e, y1_e;
  logic signed [RW-1:0] xm_d, ym_d, hx_d, hy_d;
  logic                 bypass_d;

  logic                 s3_vld_q;
  logic signed [RW-1:0] xm_q, ym_q, hx_q, hy_q;
  logic                 bypass_q;
  geom_t                geom_q;

  // stage 4
  logic                 s4_vld_q;
  verdict_e             verdict_q;
  logic signed [NW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [SIZE_W-1:0]    w_q, h_q;

  assign en4     = !s4_vld_q || ready_i;
  assign en3     = !s3_vld_q || en4;
  assign ready_o = en3;

  assign s_ext = $signed({{(RW-SCALE_W){1'b0}}, rescale_i});
  assign x0_e  = RW'($signed(geom_i.x0));
  assign x1_e  = RW'($signed(geom_i.x1));
  assign y0_e  = RW'($signed(geom_i.y0));
  assign y1_e  = RW'($signed(geom_i.y1));
  assign xm_d  = (x0_e + x1_e) <<< FRAC_BITS;
  assign ym_d  = (y0_e + y1_e) <<< FRAC_BITS;
  assign hx_d  = s_ext * (x1_e - x0_e);
  assign hy_d  = s_ext * (y1_e - y0_e);
  assign bypass_d = (32'(rescale_i) == UNITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (en3) s3_vld_q <= valid_i;
      if (en4) s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      xm_q     <= xm_d;
      ym_q     <= ym_d;
      hx_q     <= hx_d;
      hy_q     <= hy_d;
      bypass_q <= bypass_d;
      geom_q   <= geom_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      verdict_q <= geom_q.verdict;
      w_q       <= geom_q.w;
      h_q       <= geom_q.h;
      if (bypass_q) begin
        x0_q <= NW'($signed(geom_q.x0));
        x1_q <= NW'($signed(geom_q.x1));
        y0_q <= NW'($signed(geom_q.y0));
        y1_q <= NW'($signed(geom_q.y1));
      end else begin
        x0_q <= trunc_q(xm_q - hx_q);
        x1_q <= trunc_q(xm_q + hx_q);
        y0_q <= trunc_q(ym_q - hy_q);
        y1_q <= trunc_q(ym_q + hy_q);
      end
    end
  end

  assign valid_o   = s4_vld_q;
  assign verdict_o = verdict_q;
  assign x0_o      = x0_q;
  assign x1_o      = x1_q;
  assign y0_o      = y0_q;
  assign y1_o      = y1_q;
  assign w_o       = w_q;
  assign h_o       = h_q;

endmodule

### rtl/tile_box_to_global_filter.sv
// Top level of the tile box to global filter: config registers, geometry
// and rescale stages, final verdict and output register.
// Depends on tbg_pkg, tbg_if, tbg_cfg, tbg_geom, tbg_rescale.

// Takes one box item per clock while the output is not stalled, and returns
// one result item per box, in order. The five register stages are:
// extents, aspect cross-products and shifted corners; aspect test and
// clamp; rescale products; rescale sums with truncation; final negative
// and beyond-image checks with saturation into the output register. Each
// stage moves on when the one after it is empty or moving, so bubbles
// close up and a stalled output holds only the items already queued
// behind it. The user must write the registers over APB at byte addresses
// 0, 4 and 8 only while no item is in flight; the block does not enforce this.

module tile_box_to_global_filter #(
  parameter int FRAC_BITS  = 8,
  parameter int IMAGE_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tbg_in_if.sink                           in_box_i,
  tbg_out_if.source                        out_box_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tbg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tbg_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tbg_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import tbg_pkg::*;

  localparam int NW = coord_w(FRAC_BITS);
  localparam logic signed [NW-1:0]    SAT_HI = NW'(32767);
  localparam logic signed [NW-1:0]    SAT_LO = -NW'(32768);
  localparam logic signed [NW-1:0]    NW_ZERO = '0;

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [NW-1:0] v);
    priority if (v > SAT_HI) begin
      sat16 = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < SAT_LO) begin
      sat16 = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat16 = v[OUT_W-1:0];
    end
  endfunction

  cfg_t     cfg;
  logic     geom_vld, geom_rdy, rs_vld, rs_rdy;
  geom_t    geom;
  verdict_e rs_verdict;
  logic signed [NW-1:0] rs_x0, rs_x1, rs_y0, rs_y1, w_ext, h_ext;
  logic [SIZE_W-1:0]    rs_w, rs_h;

  logic     neg, beyond;
  verdict_e verdict_d;

  logic                    out_vld_q;
  verdict_e                verdict_q;
  logic signed [OUT_W-1:0] left_q, right_q, top_q, bottom_q;

  tbg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbg_geom #(
    .FRAC_BITS  (FRAC_BITS),
    .IMAGE_BITS (IMAGE_BITS)
  ) u_geom (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .valid_i           (in_box_i.valid),
    .ready_o           (in_box_i.ready),
    .local_left_i      (in_box_i.local_left),
    .local_right_i     (in_box_i.local_right),
    .local_top_i       (in_box_i.local_top),
    .local_bottom_i    (in_box_i.local_bottom),
    .tile_row_offset_i (in_box_i.tile_row_offset),
    .tile_col_offset_i (in_box_i.tile_col_offset),
    .tile_pad_i        (in_box_i.tile_pad),
    .image_width_i     (in_box_i.image_width),
    .image_height_i    (in_box_i.image_height),
    .valid_o           (geom_vld),
    .ready_i           (geom_rdy),
    .geom_o            (geom)
  );

  tbg_rescale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rescale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rescale_i (cfg.rescale),
    .valid_i   (geom_vld),
    .ready_o   (geom_rdy),
    .geom_i    (geom),
    .valid_o   (rs_vld),
    .ready_i   (rs_rdy),
    .verdict_o (rs_verdict),
    .x0_o      (rs_x0),
    .x1_o      (rs_x1),
    .y0_o      (rs_y0),
    .y1_o      (rs_y1),
    .w_o       (rs_w),
    .h_o       (rs_h)
  );

  assign rs_rdy = !out_vld_q || out_box_o.ready;

  assign w_ext  = $signed({{(NW-SIZE_W){1'b0}}, rs_w});
  assign h_ext  = $signed({{(NW-SIZE_W){1'b0}}, rs_h});
  assign neg    = (rs_x0 < NW_ZERO) || (rs_x1 < NW_ZERO) ||
                  (rs_y0 < NW_ZERO) || (rs_y1 < NW_ZERO);
  assign beyond = (rs_x1 > w_ext) || (rs_y1 > h_ext);

  always_comb begin
    priority if (rs_verdict != V_KEPT) begin
      verdict_d = rs_verdict;
    end else if (neg) begin
      verdict_d = V_NEG;
    end else if (beyond) begin
      verdict_d = V_BEYOND;
    end else begin
      verdict_d = V_KEPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rs_rdy) begin
      out_vld_q <= rs_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_rdy) begin
      verdict_q <= verdict_d;
      if (verdict_d == V_KEPT) begin
        left_q   <= sat16(rs_x0);
        right_q  <= sat16(rs_x1);
        top_q    <= sat16(rs_y0);
        bottom_q <= sat16(rs_y1);
      end else begin
        left_q   <= '0;
        right_q  <= '0;
        top_q    <= '0;
        bottom_q <= '0;
      end
    end
  end

  assign out_box_o.valid         = out_vld_q;
  assign out_box_o.verdict       = verdict_q;
  assign out_box_o.global_left   = left_q;
  assign out_box_o.global_right  = right_q;
  assign out_box_o.global_top    = top_q;
  assign out_box_o.global_bottom = bottom_q;

  // rejected items carry an all-zero box
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (verdict_q != V_KEPT) |->
      (left_q == '0) && (right_q == '0) && (top_q == '0) && (bottom_q == '0))
    else $error("rejected item with nonzero box");

  // kept items never leave a negative corner
  a_kept_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (verdict_q == V_KEPT) |->
      !left_q[OUT_W-1] && !right_q[OUT_W-1] && !top_q[OUT_W-1] && !bottom_q[OUT_W-1])
    else $error("kept item with negative corner");

  // input backpressure only when the output is stalled
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_box_i.ready |-> out_vld_q && !out_box_o.ready)
    else $error("input stalled while output is free");

  // an item reaching the last stage while output is free appears next cycle
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_vld && rs_rdy |=> out_vld_q)
    else $error("item lost at the output register");

endmodule
